@@ rtl/core/fc2tc_pkg.sv @@
// Shared types and constants for the frame count to timecode converter.
`timescale 1ns / 1ps
`default_nettype none

package fc2tc_pkg;

  // Field widths of the result and configuration.
  localparam int HOURS_W = 13;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int FRM_W   = 7;
  localparam int TB_W    = 7;

  // Internal widths: skip count, frames per minute, frames per ten minutes,
  // and the divider remainder (wide enough for frames per hour).
  localparam int SKIP_W = 3;
  localparam int FMIN_W = 13;
  localparam int TEN_W  = 17;
  localparam int DIV_W  = 19;

  // Quotient bits needed by the short divisions.
  localparam int Q_TEN_BITS = 3;
  localparam int Q_MIN_BITS = 4;
  localparam int Q_SEC_BITS = 6;

  localparam logic [TB_W-1:0] TB_RESET = 7'd30;

  // Register indexes on the configuration port.
  localparam logic REG_TIMEBASE = 1'b0;
  localparam logic REG_DROP     = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_PREP,
    OP_STEP,
    OP_LOAD_TEN,
    OP_LOAD_MIN,
    OP_LOAD_FRM_DIRECT,
    OP_LOAD_FRM_SHORT,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic past_full_min;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/fc2tc_ctrl.sv @@
// Sequencer that steps the shared divider through three or four divisions.
`timescale 1ns / 1ps
`default_nettype none

module fc2tc_ctrl import fc2tc_pkg::*; #(
  parameter int FRAME_BITS = 24
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  localparam int CW = $clog2(FRAME_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_H,
    ST_LD_T,
    ST_DIV_T,
    ST_LD_M,
    ST_DIV_M,
    ST_LD_F,
    ST_DIV_F,
    ST_FIN
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last_step;

  assign last_step  = (cnt_q == CW'(1));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        cnt_d    = CW'(FRAME_BITS);
        state_d  = ST_DIV_H;
      end
      ST_DIV_H: begin
        cmd_o.op = OP_STEP;
        cnt_d    = cnt_q - CW'(1);
        if (last_step) begin
          state_d = ST_LD_T;
        end
      end
      ST_LD_T: begin
        cmd_o.op = OP_LOAD_TEN;
        cnt_d    = CW'(Q_TEN_BITS);
        state_d  = ST_DIV_T;
      end
      ST_DIV_T: begin
        cmd_o.op = OP_STEP;
        cnt_d    = cnt_q - CW'(1);
        if (last_step) begin
          state_d = ST_LD_M;
        end
      end
      ST_LD_M: begin
        // The first minute of a ten-minute block is never short.
        if (status_i.past_full_min) begin
          cmd_o.op = OP_LOAD_MIN;
          cnt_d    = CW'(Q_MIN_BITS);
          state_d  = ST_DIV_M;
        end else begin
          cmd_o.op = OP_LOAD_FRM_DIRECT;
          cnt_d    = CW'(Q_SEC_BITS);
          state_d  = ST_DIV_F;
        end
      end
      ST_DIV_M: begin
        cmd_o.op = OP_STEP;
        cnt_d    = cnt_q - CW'(1);
        if (last_step) begin
          state_d = ST_LD_F;
        end
      end
      ST_LD_F: begin
        cmd_o.op = OP_LOAD_FRM_SHORT;
        cnt_d    = CW'(Q_SEC_BITS);
        state_d  = ST_DIV_F;
      end
      ST_DIV_F: begin
        cmd_o.op = OP_STEP;
        cnt_d    = cnt_q - CW'(1);
        if (last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fc2tc_dp.sv @@
// Datapath: timebase constants, shared restoring divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module fc2tc_dp import fc2tc_pkg::*; #(
  parameter int FRAME_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 status_o,
  input  wire logic [TB_W-1:0]       cfg_timebase_i,
  input  wire logic                  cfg_drop_i,
  input  wire logic [FRAME_BITS-1:0] frame_number_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [HOURS_W-1:0]         hours_o,
  output logic [MIN_W-1:0]           minutes_o,
  output logic [SEC_W-1:0]           seconds_o,
  output logic [FRM_W-1:0]           frames_o,
  output logic                       drop_flag_o
);

  localparam int FW = FRAME_BITS;

  // Per-item constants.
  logic [TB_W-1:0]   tb_q, tb_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic              drop_q, drop_d;
  logic [FMIN_W-1:0] fmin_q, fmin_d;
  logic [FMIN_W-1:0] smin_q, smin_d;
  logic [TEN_W-1:0]  ten_q, ten_d;

  // Divider state: remainder, dividend/quotient shifter and divisor.
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [FW-1:0]    dvd_q, dvd_d;
  logic [DIV_W-1:0] div_q, div_d;

  // Partial results.
  logic [HOURS_W-1:0] h_q, h_d;
  logic [MIN_W-1:0]   m_q, m_d;

  // Output register.
  logic               ovalid_q, ovalid_d;
  logic [HOURS_W-1:0] ohours_q, ohours_d;
  logic [MIN_W-1:0]   omin_q, omin_d;
  logic [SEC_W-1:0]   osec_q, osec_d;
  logic [FRM_W-1:0]   ofrm_q, ofrm_d;
  logic               odrop_q, odrop_d;

  logic [TB_W-1:0]   tb_eff;
  logic [SKIP_W-1:0] skip_nom;
  logic [FMIN_W-1:0] fmin_c;
  logic [TEN_W-1:0]  ten_c;
  logic [DIV_W-1:0]  hour_c;
  logic [DIV_W+1:0]  trial;
  logic              fits;
  logic [DIV_W-1:0]  r2;
  logic [DIV_W-1:0]  pos;
  logic [MIN_W-1:0]  m_block;

  // A timebase of zero counts as one; skipping is off when it would not fit.
  assign tb_eff   = (cfg_timebase_i == '0) ? TB_W'(1) : cfg_timebase_i;
  assign skip_nom = (tb_eff == TB_W'(60)) ? SKIP_W'(4) : SKIP_W'(2);

  assign fmin_c = FMIN_W'({{(FMIN_W-TB_W){1'b0}}, tb_q} * FMIN_W'(60));
  assign ten_c  = TEN_W'({{(TEN_W-TB_W){1'b0}}, tb_q} * TEN_W'(600))
                - TEN_W'({{(TEN_W-SKIP_W){1'b0}}, skip_q} * TEN_W'(9));
  assign hour_c = DIV_W'({{(DIV_W-TB_W){1'b0}}, tb_q} * DIV_W'(3600))
                - DIV_W'({{(DIV_W-SKIP_W){1'b0}}, skip_q} * DIV_W'(54));

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {1'b0, rem_q, dvd_q[FW-1]} - {2'b00, div_q};
  assign fits  = ~trial[DIV_W+1];

  assign r2      = rem_q - {{(DIV_W-FMIN_W){1'b0}}, fmin_q};
  assign pos     = rem_q + {{(DIV_W-SKIP_W){1'b0}}, skip_q};
  assign m_block = MIN_W'({{(MIN_W-Q_TEN_BITS){1'b0}}, dvd_q[Q_TEN_BITS-1:0]}
                          * MIN_W'(10));

  assign status_o.past_full_min = (rem_q >= {{(DIV_W-FMIN_W){1'b0}}, fmin_q});
  assign status_o.out_free      = ~ovalid_q | out_ready_i;

  always_comb begin
    tb_d     = tb_q;
    skip_d   = skip_q;
    drop_d   = drop_q;
    fmin_d   = fmin_q;
    smin_d   = smin_q;
    ten_d    = ten_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    div_d    = div_q;
    h_d      = h_q;
    m_d      = m_q;
    ovalid_d = ovalid_q & ~out_ready_i;
    ohours_d = ohours_q;
    omin_d   = omin_q;
    osec_d   = osec_q;
    ofrm_d   = ofrm_q;
    odrop_d  = odrop_q;
    case (cmd_i.op)
      OP_CAPTURE: begin
        tb_d   = tb_eff;
        drop_d = cfg_drop_i;
        skip_d = (cfg_drop_i && (tb_eff > {{(TB_W-SKIP_W){1'b0}}, skip_nom}))
               ? skip_nom : '0;
        rem_d  = '0;
        dvd_d  = frame_number_i;
      end
      OP_PREP: begin
        fmin_d = fmin_c;
        smin_d = fmin_c - {{(FMIN_W-SKIP_W){1'b0}}, skip_q};
        ten_d  = ten_c;
        div_d  = hour_c;
      end
      OP_STEP: begin
        rem_d = fits ? trial[DIV_W-1:0] : {rem_q[DIV_W-2:0], dvd_q[FW-1]};
        dvd_d = {dvd_q[FW-2:0], fits};
      end
      OP_LOAD_TEN: begin
        h_d   = dvd_q[HOURS_W-1:0];
        div_d = {{(DIV_W-TEN_W){1'b0}}, ten_q};
        rem_d = rem_q >> Q_TEN_BITS;
        dvd_d = '0;
        dvd_d[FW-1 -: Q_TEN_BITS] = rem_q[Q_TEN_BITS-1:0];
      end
      OP_LOAD_MIN: begin
        m_d   = m_block;
        div_d = {{(DIV_W-FMIN_W){1'b0}}, smin_q};
        rem_d = r2 >> Q_MIN_BITS;
        dvd_d = '0;
        dvd_d[FW-1 -: Q_MIN_BITS] = r2[Q_MIN_BITS-1:0];
      end
      OP_LOAD_FRM_DIRECT: begin
        m_d   = m_block;
        div_d = {{(DIV_W-TB_W){1'b0}}, tb_q};
        rem_d = rem_q >> Q_SEC_BITS;
        dvd_d = '0;
        dvd_d[FW-1 -: Q_SEC_BITS] = rem_q[Q_SEC_BITS-1:0];
      end
      OP_LOAD_FRM_SHORT: begin
        m_d   = m_q + MIN_W'(1) + {{(MIN_W-Q_MIN_BITS){1'b0}}, dvd_q[Q_MIN_BITS-1:0]};
        div_d = {{(DIV_W-TB_W){1'b0}}, tb_q};
        rem_d = pos >> Q_SEC_BITS;
        dvd_d = '0;
        dvd_d[FW-1 -: Q_SEC_BITS] = pos[Q_SEC_BITS-1:0];
      end
      OP_FINISH: begin
        ovalid_d = 1'b1;
        ohours_d = h_q;
        omin_d   = m_q;
        osec_d   = dvd_q[SEC_W-1:0];
        ofrm_d   = rem_q[FRM_W-1:0];
        odrop_d  = drop_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tb_q     <= tb_d;
    skip_q   <= skip_d;
    drop_q   <= drop_d;
    fmin_q   <= fmin_d;
    smin_q   <= smin_d;
    ten_q    <= ten_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    div_q    <= div_d;
    h_q      <= h_d;
    m_q      <= m_d;
    ohours_q <= ohours_d;
    omin_q   <= omin_d;
    osec_q   <= osec_d;
    ofrm_q   <= ofrm_d;
    odrop_q  <= odrop_d;
  end

  assign out_valid_o = ovalid_q;
  assign hours_o     = ohours_q;
  assign minutes_o   = omin_q;
  assign seconds_o   = osec_q;
  assign frames_o    = ofrm_q;
  assign drop_flag_o = odrop_q;

endmodule

`default_nettype wire

@@ rtl/core/frame_count_to_timecode.sv @@
// Top level of the frame count to SMPTE timecode converter.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                        Payload
// input     in         in_valid_i / in_ready_o          frame_number_i
// output    out        out_valid_o / out_ready_i        hours, minutes, seconds, frames, drop
// config    in         psel, penable, pwrite, pready    paddr, pwdata / prdata
//
// The block takes no new input transfer until the current item is finished; an item
// that falls past the first minute of a ten-minute block needs one more division.
// One restoring divider retires a quotient bit per cycle over three or four divisions.
// Reset sets timebase 30 and non-drop counting and empties the output register.
// A finished result waits in the output register while the next input transfer is
// taken; the sequencer stalls only if a second result is ready before the first is taken.

module frame_count_to_timecode import fc2tc_pkg::*; #(
  parameter int FRAME_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input channel.
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [FRAME_BITS-1:0] frame_number_i,
  // Output channel.
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [HOURS_W-1:0]         hours_o,
  output logic [MIN_W-1:0]           minutes_o,
  output logic [SEC_W-1:0]           seconds_o,
  output logic [FRM_W-1:0]           frames_o,
  output logic                       drop_flag_o,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [TB_W-1:0] timebase_q, timebase_d;
  logic            drop_q, drop_d;
  logic            reg_wr;
  logic            reg_idx;
  dp_cmd_t         cmd;
  dp_status_t      status;

  // The register index is the word address; a write completes in the access
  // phase, and the port never inserts wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    timebase_d = timebase_q;
    drop_d     = drop_q;
    if (reg_wr) begin
      case (reg_idx)
        REG_TIMEBASE: timebase_d = pwdata[TB_W-1:0];
        REG_DROP:     drop_d     = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timebase_q <= TB_RESET;
      drop_q     <= 1'b0;
    end else begin
      timebase_q <= timebase_d;
      drop_q     <= drop_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMEBASE: prdata = {{(32-TB_W){1'b0}}, timebase_q};
      REG_DROP:     prdata = {31'b0, drop_q};
      default:      prdata = '0;
    endcase
  end

  fc2tc_ctrl #(
    .FRAME_BITS (FRAME_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fc2tc_dp #(
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_timebase_i (timebase_q),
    .cfg_drop_i     (drop_q),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hours_o        (hours_o),
    .minutes_o      (minutes_o),
    .seconds_o      (seconds_o),
    .frames_o       (frames_o),
    .drop_flag_o    (drop_flag_o)
  );

endmodule

`default_nettype wire

@@ tb/frame_count_to_timecode_test.sv @@
// Self-checking testbench for the frame count to SMPTE timecode converter.
`timescale 1ns / 1ps
`default_nettype none

module frame_count_to_timecode_test import fc2tc_pkg::*;;

  localparam int FRAME_BITS = 24;
  localparam longint unsigned MAX_COUNT = (64'd1 << FRAME_BITS) - 1;
  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_CHUNKS = 12;
  localparam int CHUNK_ITEMS = 85;
  localparam int REPORT_LIMIT = 10;
  // Each register sits at four times its index on the configuration port.
  localparam logic [2:0] ADDR_TIMEBASE = {REG_TIMEBASE, 2'b00};
  localparam logic [2:0] ADDR_DROP     = {REG_DROP, 2'b00};

  // One converted timecode, in the same field order as the output ports.
  typedef struct packed {
    logic [HOURS_W-1:0] hours;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [FRM_W-1:0]   frames;
    logic               drop_flag;
  } timecode_t;

  // One row of the directed table. When has_tc is set, tc holds a hand-worked
  // answer; otherwise the row is checked against the predictor.
  typedef struct {
    logic [TB_W-1:0]       rate;
    logic                  drop;
    logic [FRAME_BITS-1:0] count;
    bit                    has_tc;
    timecode_t             tc;
  } frame_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [FRAME_BITS-1:0] frame_number_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [HOURS_W-1:0]    hours_o;
  logic [MIN_W-1:0]      minutes_o;
  logic [SEC_W-1:0]      seconds_o;
  logic [FRM_W-1:0]      frames_o;
  logic                  drop_flag_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Shadow copy of the two configuration registers, as of reset.
  logic [TB_W-1:0] cur_rate = TB_RESET;
  logic            cur_drop = 1'b0;

  // Timecodes still owed by the block, oldest first.
  timecode_t timecode_due [$];
  int fault_count = 0;
  int report_count = 0;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls. The stimulus process changes them from phase to phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  frame_count_to_timecode #(
    .FRAME_BITS(FRAME_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hours_o        (hours_o),
    .minutes_o      (minutes_o),
    .seconds_o      (seconds_o),
    .frames_o       (frames_o),
    .drop_flag_o    (drop_flag_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predicts the timecode of one frame count. Whole hours and ten-minute
  // blocks come off first; the first minute of a block is always full length,
  // the other nine lose the dropped labels at their start.
  function automatic timecode_t frames_to_timecode(logic [FRAME_BITS-1:0] count,
                                                   logic [TB_W-1:0] rate_cfg,
                                                   logic drop_cfg);
    longint unsigned rate, skip, dropped, full_min, short_min, ten_len, hour_len;
    longint unsigned rest, mins, pos;
    timecode_t tc;
    // A timebase of zero counts as one frame per second.
    rate = (rate_cfg == '0) ? 64'd1 : 64'(rate_cfg);
    skip = (rate == 60) ? 64'd4 : 64'd2;
    // At one or two frames per second there is nothing to skip.
    dropped = (drop_cfg && rate > skip) ? skip : 64'd0;
    full_min = rate * 60;
    short_min = full_min - dropped;
    ten_len = full_min * 10 - 9 * dropped;
    hour_len = 6 * ten_len;
    rest = count % hour_len;
    mins = 10 * (rest / ten_len);
    rest = rest % ten_len;
    if (rest < full_min) begin
      pos = rest;
    end else begin
      rest = rest - full_min;
      mins = mins + 1 + rest / short_min;
      pos = rest % short_min + dropped;
    end
    tc.hours = HOURS_W'(count / hour_len);
    tc.minutes = MIN_W'(mins);
    tc.seconds = SEC_W'(pos / rate);
    tc.frames = FRM_W'(pos % rate);
    tc.drop_flag = drop_cfg;
    return tc;
  endfunction

  // Picks a random frame count. Half of the picks land within three frames of
  // a minute boundary (drop-frame aware), where the rollover logic works hardest.
  function automatic logic [FRAME_BITS-1:0] pick_frame(logic [TB_W-1:0] rate_cfg,
                                                       logic drop_cfg);
    longint unsigned rate, dropped, full_min, ten_len, base, minute_in_block;
    rate = (rate_cfg == '0) ? 64'd1 : 64'(rate_cfg);
    dropped = (drop_cfg && rate > 2) ? ((rate == 60) ? 64'd4 : 64'd2) : 64'd0;
    full_min = rate * 60;
    ten_len = full_min * 10 - 9 * dropped;
    case ($urandom_range(0, 3))
      0: return FRAME_BITS'($urandom());
      1: return FRAME_BITS'($urandom_range(0, 40000));
      default: begin
        base = ten_len * $urandom_range(0, 32'(MAX_COUNT / ten_len));
        minute_in_block = $urandom_range(0, 9);
        if (minute_in_block != 0) begin
          base = base + full_min + (minute_in_block - 1) * (full_min - dropped);
        end
        base = base + $urandom_range(0, 6);
        base = (base < 3) ? 64'd0 : base - 3;
        if (base > MAX_COUNT) begin
          base = MAX_COUNT;
        end
        return FRAME_BITS'(base);
      end
    endcase
  endfunction

  task automatic wait_for_results();
    while (timecode_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access cycle meets pready.
  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops feeding frames, lets every owed timecode come out, then writes both
  // registers. Bits above each register's width carry random junk, which the
  // block must ignore.
  task automatic set_timebase_and_drop(logic [TB_W-1:0] rate, logic drop);
    in_valid_i <= 1'b0;
    wait_for_results();
    write_register(ADDR_TIMEBASE, ($urandom() & ~32'h7F) | 32'(rate));
    write_register(ADDR_DROP, ($urandom() & ~32'h1) | 32'(drop));
    cur_rate = rate;
    cur_drop = drop;
  endtask

  // Offers one frame count after a random number of idle cycles and holds it
  // until the transfer happens. Valid is left high on return, so back-to-back
  // frames go out without a gap.
  task automatic send_frame(logic [FRAME_BITS-1:0] count, timecode_t tc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_number_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    timecode_due.push_back(tc);
  endtask

  // Receiver side: stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every output transfer is matched against the oldest owed timecode.
  always @(posedge clk_i) begin
    timecode_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{hours_o, minutes_o, seconds_o, frames_o, drop_flag_o};
      if (timecode_due.size() == 0) begin
        fault_count++;
        if (report_count < REPORT_LIMIT) begin
          $display("%0t: unexpected timecode %0d:%0d:%0d:%0d drop %0d", $realtime,
                   got.hours, got.minutes, got.seconds, got.frames, got.drop_flag);
        end
        report_count++;
      end else begin
        want = timecode_due.pop_front();
        if (got.hours !== want.hours || got.minutes !== want.minutes ||
            got.seconds !== want.seconds || got.frames !== want.frames ||
            got.drop_flag !== want.drop_flag) begin
          fault_count++;
          if (report_count < REPORT_LIMIT) begin
            $display("%0t: mismatch, expected %0d:%0d:%0d:%0d/%0d, got %0d:%0d:%0d:%0d/%0d",
                     $realtime, want.hours, want.minutes, want.seconds, want.frames,
                     want.drop_flag, got.hours, got.minutes, got.seconds, got.frames,
                     got.drop_flag);
          end
          report_count++;
        end
      end
    end
  end

  initial begin
    frame_row_t rows [DIRECTED_ROWS];
    timecode_t tc;
    logic [TB_W-1:0] next_rate;
    logic next_drop;
    logic [FRAME_BITS-1:0] count;

    // Directed table. The first rows run on the reset configuration; later
    // rows change it, which forces a drain and a register write.
    rows = '{
      // Reset timebase 30, non-drop: zero, end of the first second, rollover, largest count.
      '{7'd30,  1'b0, 24'd0,        1'b1, '{13'd0, 6'd0, 6'd0, 7'd0, 1'b0}},
      '{7'd30,  1'b0, 24'd29,       1'b1, '{13'd0, 6'd0, 6'd0, 7'd29, 1'b0}},
      '{7'd30,  1'b0, 24'd30,       1'b1, '{13'd0, 6'd0, 6'd1, 7'd0, 1'b0}},
      '{7'd30,  1'b0, 24'hFFFFFF,   1'b1, '{13'd155, 6'd20, 6'd40, 7'd15, 1'b0}},
      // Drop-frame at 30: minute one starts at label 2, minute ten at 0.
      '{7'd30,  1'b1, 24'd1799,     1'b1, '{13'd0, 6'd0, 6'd59, 7'd29, 1'b1}},
      '{7'd30,  1'b1, 24'd1800,     1'b1, '{13'd0, 6'd1, 6'd0, 7'd2, 1'b1}},
      '{7'd30,  1'b1, 24'd17981,    1'b0, '0},
      '{7'd30,  1'b1, 24'd17982,    1'b1, '{13'd0, 6'd10, 6'd0, 7'd0, 1'b1}},
      '{7'd30,  1'b1, 24'hFFFFFF,   1'b0, '0},
      // Timebase 60 skips four labels instead of two.
      '{7'd60,  1'b1, 24'd3600,     1'b1, '{13'd0, 6'd1, 6'd0, 7'd4, 1'b1}},
      '{7'd60,  1'b1, 24'hFFFFFF,   1'b0, '0},
      '{7'd60,  1'b0, 24'd3600,     1'b1, '{13'd0, 6'd1, 6'd0, 7'd0, 1'b0}},
      // Timebase zero behaves as one; the largest count gives the largest hour.
      '{7'd0,   1'b0, 24'd59,       1'b1, '{13'd0, 6'd0, 6'd59, 7'd0, 1'b0}},
      '{7'd0,   1'b0, 24'd3600,     1'b1, '{13'd1, 6'd0, 6'd0, 7'd0, 1'b0}},
      '{7'd0,   1'b0, 24'hFFFFFF,   1'b1, '{13'd4660, 6'd20, 6'd15, 7'd0, 1'b0}},
      // At one and two frames per second drop-frame skips nothing, but the
      // flag still follows the register. At three it skips two labels.
      '{7'd1,   1'b1, 24'd60,       1'b1, '{13'd0, 6'd1, 6'd0, 7'd0, 1'b1}},
      '{7'd2,   1'b1, 24'd120,      1'b1, '{13'd0, 6'd1, 6'd0, 7'd0, 1'b1}},
      '{7'd3,   1'b1, 24'd180,      1'b1, '{13'd0, 6'd1, 6'd0, 7'd2, 1'b1}},
      // Timebases above the nominal range are used as written.
      '{7'd127, 1'b0, 24'd126,      1'b1, '{13'd0, 6'd0, 6'd0, 7'd126, 1'b0}},
      '{7'd127, 1'b1, 24'hFFFFFF,   1'b0, '0},
      '{7'd120, 1'b1, 24'd7200,     1'b1, '{13'd0, 6'd1, 6'd0, 7'd2, 1'b1}},
      '{7'd120, 1'b0, 24'hFFFFFF,   1'b0, '0},
      '{7'd24,  1'b1, 24'd54321,    1'b0, '0},
      '{7'd25,  1'b1, 24'd1500,     1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First phase: sender idles often, receiver stalls most of the time.
    send_idle_pct = 27;
    recv_stall_pct = 75;
    foreach (rows[i]) begin
      if (rows[i].rate != cur_rate || rows[i].drop != cur_drop) begin
        set_timebase_and_drop(rows[i].rate, rows[i].drop);
      end
      tc = rows[i].has_tc ? rows[i].tc
                          : frames_to_timecode(rows[i].count, cur_rate, cur_drop);
      send_frame(rows[i].count, tc);
    end

    // Random part in chunks. Each chunk drains the block, picks a new
    // configuration and runs a batch of frames. The idle pattern swaps after
    // a third of the chunks and switches off for the last third.
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      if (chunk == RANDOM_CHUNKS / 3) begin
        send_idle_pct = 75;
        recv_stall_pct = 27;
      end else if (chunk == 2 * RANDOM_CHUNKS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(0, 4))
        0: next_rate = TB_W'($urandom_range(0, 127));
        1: next_rate = 7'd60;
        2: next_rate = ($urandom_range(0, 1) != 0) ? 7'd30 : 7'd24;
        3: next_rate = TB_W'($urandom_range(0, 3));
        default: next_rate = TB_W'($urandom_range(118, 127));
      endcase
      next_drop = 1'($urandom_range(0, 1));
      set_timebase_and_drop(next_rate, next_drop);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        count = pick_frame(cur_rate, cur_drop);
        send_frame(count, frames_to_timecode(count, cur_rate, cur_drop));
      end
    end

    in_valid_i <= 1'b0;
    wait_for_results();
    // Give a stray extra result time to show up.
    repeat (60) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
